// ===== hw/rtl/me_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
package me_pkg;

  // Width of the base field, which is also the longest operand scan of the multiplier.
  localparam int BASE_WIDTH = 32;

  // Width of the multiplier's bit counter, wide enough to hold BASE_WIDTH itself.
  localparam int MUL_CNT_W = $clog2(BASE_WIDTH + 1);

  // Modulus after reset, truncated to the configured width where it is used.
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } me_state_t;

  // Command from the sequencer to the serial multiplier.
  typedef struct packed {
    logic start;  // latch operands and begin a product
    logic full;   // scan all BASE_WIDTH bits of b instead of the modulus width
  } mul_ctl_t;

endpackage

// ===== hw/rtl/me_stream_if.sv =====
// Valid/ready channel interfaces for the operand and result streams.
interface me_operand_if #(
  parameter int EXP_WIDTH = 63
);
  logic                 valid;
  logic                 ready;
  logic [31:0]          base_value;
  logic [EXP_WIDTH-1:0] exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface me_result_if #(
  parameter int MOD_WIDTH = 31
);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink (input valid, input power_mod, output ready);
endinterface

// ===== hw/rtl/me_modmul.sv =====
// Bit-serial interleaved modular multiplier, one bit of b per cycle, MSB first.
module me_modmul #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  me_pkg::mul_ctl_t              ctl,
  input  logic [MOD_WIDTH-1:0]          a_in,
  input  logic [me_pkg::BASE_WIDTH-1:0] b_in,
  input  logic [MOD_WIDTH-1:0]          m,
  output logic                          done,
  output logic [MOD_WIDTH-1:0]          prod
);

  localparam int SHIFT = me_pkg::BASE_WIDTH - MOD_WIDTH;

  logic                           busy;
  logic [me_pkg::MUL_CNT_W-1:0]   cnt;
  logic [MOD_WIDTH-1:0]           a_reg;
  logic [me_pkg::BASE_WIDTH-1:0]  b_reg;
  logic [MOD_WIDTH+1:0]           t;
  logic [MOD_WIDTH+1:0]           m1;
  logic [MOD_WIDTH+1:0]           m2;
  logic [MOD_WIDTH+1:0]           t_red;
  logic [MOD_WIDTH-1:0]           prod_next;

  // With prod < m and a <= m, 2*prod + a stays below 3m, so at most 2m comes off.
  always_comb begin
    t  = {1'b0, prod, 1'b0} + (b_reg[me_pkg::BASE_WIDTH-1] ? {2'b00, a_reg} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2) begin
      t_red = t - m2;
    end else if (t >= m1) begin
      t_red = t - m1;
    end else begin
      t_red = t;
    end
    prod_next = t_red[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.full ? me_pkg::MUL_CNT_W'(me_pkg::BASE_WIDTH)
                         : me_pkg::MUL_CNT_W'(MOD_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == me_pkg::MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_reg <= a_in;
      b_reg <= ctl.full ? b_in : (b_in << SHIFT);
      prod  <= '0;
    end else if (busy) begin
      b_reg <= b_reg << 1;
      prod  <= prod_next;
    end
  end

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// The operand channel carries one beat per item: base_value and exponent.
// The result channel returns one beat per item: power_mod, the base raised
// to the exponent modulo the configured modulus. A modulus of zero acts as
// a modulus of one. A zero exponent always returns 1.
// The modulus is written through cfg_we/cfg_wdata and must only change
// while no item is in flight; it is sampled when an item is accepted.
// All arithmetic runs on one bit-serial modular multiplier that consumes
// one bit of its second operand per cycle. It first reduces the base over
// all BASE_WIDTH bits; then, for each exponent bit up to the highest set
// bit, the sequencer passes through ST_CHECK and runs a product when the
// bit is set and a squaring unless no set bit remains, each over MOD_WIDTH
// bits. One item at a time. Once a result is finished the next item is
// accepted even while that result still waits in the output register; a
// stalled receiver holds it there, and a second finished result waits
// behind it in the sequencer. Reset idles the sequencer, empties the output
// register and loads the modulus with 1000000007 truncated to MOD_WIDTH
// bits.
module modular_exponentiation #(
  parameter int MOD_WIDTH = 31,
  parameter int EXP_WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  me_operand_if.sink           operand,
  me_result_if.source          result,
  input  logic                 cfg_we,
  input  logic [MOD_WIDTH-1:0] cfg_wdata
);

  me_pkg::me_state_t state;
  me_pkg::me_state_t state_next;

  // Configured modulus, and the effective modulus captured for the item in work.
  logic [MOD_WIDTH-1:0]          modulus;
  logic [MOD_WIDTH-1:0]          m_eff;

  // Item working set: base, remaining exponent bits, running power, accumulator.
  logic [me_pkg::BASE_WIDTH-1:0] base;
  logic [EXP_WIDTH-1:0]          exp_sr;
  logic [MOD_WIDTH-1:0]          pw;
  logic [MOD_WIDTH-1:0]          acc;

  // Multiplier hookup.
  me_pkg::mul_ctl_t              mul_ctl;
  logic [MOD_WIDTH-1:0]          mul_a;
  logic [me_pkg::BASE_WIDTH-1:0] mul_b;
  logic                          mul_done;
  logic [MOD_WIDTH-1:0]          mul_prod;

  logic                          accept;
  logic                          out_load;
  logic                          last_bit;

  assign accept   = operand.valid && operand.ready;
  assign last_bit = (exp_sr >> 1) == '0;

  me_modmul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_modmul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a_in (mul_a),
    .b_in (mul_b),
    .m    (m_eff),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= me_pkg::MODULUS_RESET[MOD_WIDTH-1:0];
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= me_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, multiplier commands and operand selection.
  always_comb begin
    state_next     = state;
    operand.ready  = 1'b0;
    mul_ctl.start  = 1'b0;
    mul_ctl.full   = 1'b0;
    mul_a          = pw;
    mul_b          = me_pkg::BASE_WIDTH'(pw);
    out_load       = 1'b0;
    case (state)
      me_pkg::ST_IDLE: begin
        operand.ready = 1'b1;
        if (operand.valid) begin
          state_next = me_pkg::ST_LOAD;
        end
      end
      me_pkg::ST_LOAD: begin
        // Reduce the base as base * 1 over all of its bits.
        mul_ctl.start = 1'b1;
        mul_ctl.full  = 1'b1;
        mul_a         = MOD_WIDTH'(1);
        mul_b         = base;
        state_next    = me_pkg::ST_REDUCE;
      end
      me_pkg::ST_REDUCE: begin
        if (mul_done) begin
          state_next = me_pkg::ST_CHECK;
        end
      end
      me_pkg::ST_CHECK: begin
        if (exp_sr == '0) begin
          state_next = me_pkg::ST_FINISH;
        end else if (exp_sr[0]) begin
          mul_ctl.start = 1'b1;
          mul_b         = me_pkg::BASE_WIDTH'(acc);
          state_next    = me_pkg::ST_MUL;
        end else begin
          mul_ctl.start = 1'b1;
          state_next    = me_pkg::ST_SQR;
        end
      end
      me_pkg::ST_MUL: begin
        if (mul_done) begin
          if (last_bit) begin
            // No set bit remains: the final squaring is not needed.
            state_next = me_pkg::ST_FINISH;
          end else begin
            mul_ctl.start = 1'b1;
            state_next    = me_pkg::ST_SQR;
          end
        end
      end
      me_pkg::ST_SQR: begin
        if (mul_done) begin
          state_next = me_pkg::ST_CHECK;
        end
      end
      me_pkg::ST_FINISH: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = me_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = me_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base   <= operand.base_value;
      exp_sr <= operand.exponent;
      acc    <= MOD_WIDTH'(1);
      m_eff  <= (modulus == '0) ? MOD_WIDTH'(1) : modulus;
    end
    if (mul_done) begin
      if (state == me_pkg::ST_MUL) begin
        acc <= mul_prod;
      end else begin
        pw <= mul_prod;
      end
      if (state == me_pkg::ST_SQR) begin
        exp_sr <= exp_sr >> 1;
      end
    end
  end

  // Output register, so a waiting result does not hold up the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.power_mod <= acc;
    end
  end

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == me_pkg::ST_REDUCE || state == me_pkg::ST_MUL ||
                  state == me_pkg::ST_SQR))
    else $error("multiplier finished outside a wait state");

  a_pw_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == me_pkg::ST_CHECK) |-> (pw < m_eff))
    else $error("running power not reduced below the modulus");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == me_pkg::ST_LOAD))
    else $error("accepted item did not start base reduction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == me_pkg::ST_FINISH && result.valid && !result.ready) |=>
      (state == me_pkg::ST_FINISH))
    else $error("finished result left while output register was full");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module tb;

  // Widths match the block's defaults.
  localparam int MOD_W = 31;
  localparam int EXP_W = 63;

  // Percentage of cycles in which either side idles.
  localparam int IDLE_PCT = 27;

  // Long receiver hold-off, in cycles. It spans several short items, so two finished
  // results pile up in the block and it has to stall the operand channel.
  localparam int HOLD_CYCLES = 900;

  // After the last result we wait this long to catch any stray result beat.
  localparam int SETTLE_CYCLES = 4400;

  // Watchdog limit, in nanoseconds.
  localparam int LIMIT_NS = 40_000_000;

  localparam logic [MOD_W-1:0] MOD_MAX = '1;

  // One item in flight, together with the power that it must produce.
  typedef struct {
    logic [31:0]      base_value;
    logic [EXP_W-1:0] exponent;
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] power_mod;
  } power_job_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [MOD_W-1:0] cfg_wdata;

  me_operand_if #(.EXP_WIDTH(EXP_W)) operand ();
  me_result_if #(.MOD_WIDTH(MOD_W))  result ();

  modular_exponentiation #(
    .MOD_WIDTH(MOD_W),
    .EXP_WIDTH(EXP_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .operand  (operand),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Powers that are still owed by the block, oldest first.
  power_job_t       pending_powers[$];

  // The modulus that the block holds, tracked from reset and from every write.
  logic [MOD_W-1:0] modulus_now;

  int error_count    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int stall_cycles   = 0;
  int modulus_writes = 0;
  int send_idle_pct  = IDLE_PCT;
  int ready_idle_pct = IDLE_PCT;

  event hold_go;
  logic hold_active = 1'b0;

  always #5 clk = ~clk;

  // Right-to-left square and multiply on 64-bit words. The modulus stays below 2^31,
  // so every product fits. A zero modulus acts as one. The accumulator starts at one
  // and is never reduced by itself, which is why a zero exponent always yields one.
  function automatic logic [MOD_W-1:0] expected_power(input logic [31:0] base_in,
                                                      input logic [EXP_W-1:0] exp_in,
                                                      input logic [MOD_W-1:0] mod_in);
    logic [63:0]      mm;
    logic [63:0]      acc;
    logic [63:0]      pw;
    logic [EXP_W-1:0] rest;
    mm   = (mod_in == '0) ? 64'd1 : 64'(mod_in);
    pw   = 64'(base_in) % mm;
    acc  = 64'd1;
    rest = exp_in;
    while (rest != '0) begin
      if (rest[0]) begin
        acc = (acc * pw) % mm;
      end
      pw   = (pw * pw) % mm;
      rest = rest >> 1;
    end
    return acc[MOD_W-1:0];
  endfunction

  // Mostly short exponents keep the run fast. A share of them spans the whole
  // width, so that every exponent bit is driven both ways.
  function automatic logic [EXP_W-1:0] random_exponent();
    logic [63:0] raw;
    int          nbits;
    int          pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 5) begin
      return '0;
    end else if (pick < 70) begin
      nbits = $urandom_range(1, 16);
    end else if (pick < 88) begin
      nbits = $urandom_range(17, EXP_W - 1);
    end else begin
      nbits = EXP_W;
    end
    raw = raw & ((64'd1 << nbits) - 64'd1);
    return raw[EXP_W-1:0];
  endfunction

  // Small bases and bases near the modulus reach the reduction corner cases. The rest are full-range values.
  function automatic logic [31:0] random_base();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return 32'($urandom_range(0, 3));
    end else if (pick < 12) begin
      return 32'(modulus_now);
    end else if (pick < 16) begin
      return 32'(modulus_now) - 32'd1;
    end else if (pick < 19) begin
      return 32'(modulus_now) * 32'd2 + 32'd1;
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 30) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Offers one operand beat and returns at the edge where it is accepted. The valid
  // line stays high after that edge, so the next call can follow without a gap.
  // Callers that stop sending must lower valid in the same step.
  task automatic send_operand(input logic [31:0] base_in, input logic [EXP_W-1:0] exp_in);
    power_job_t job;
    while ($urandom_range(99) < send_idle_pct) begin
      operand.valid <= 1'b0;
      @(posedge clk);
    end
    operand.valid      <= 1'b1;
    operand.base_value <= base_in;
    operand.exponent   <= exp_in;
    @(posedge clk);
    while (!operand.ready) begin
      @(posedge clk);
    end
    job.base_value = base_in;
    job.exponent   = exp_in;
    job.modulus    = modulus_now;
    job.power_mod  = expected_power(base_in, exp_in, modulus_now);
    pending_powers.push_back(job);
    items_sent++;
  endtask

  // Stops sending and waits until every owed power has come back.
  task automatic drain_results();
    operand.valid <= 1'b0;
    while (pending_powers.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // The modulus is sampled when an item is accepted, so it only changes while the block is idle.
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    modulus_now = value;
    modulus_writes++;
  endtask

  // Powers under the reset modulus: zero and full-width operands, a base equal to the
  // modulus, and an exponent that has only its top bit set.
  task automatic test_reset_modulus();
    send_operand(32'd0, '0);
    send_operand(32'd0, 63'd1);
    send_operand('1, '1);
    send_operand(32'd1, '1);
    send_operand(32'd2, 63'd30);
    send_operand(32'(modulus_now), 63'd5);
    send_operand(32'(modulus_now) - 32'd1, 63'd2);
    send_operand(32'd3, {1'b1, 62'd0});
    drain_results();
  endtask

  // A modulus of one, a modulus of zero (which acts as one), the smallest real
  // modulus and the largest one.
  task automatic test_modulus_extremes();
    write_modulus(MOD_W'(1));
    send_operand(32'd5, '0);
    send_operand(32'd5, 63'd7);
    send_operand('1, '1);
    write_modulus('0);
    send_operand(32'd9, '0);
    send_operand(32'd9, 63'd3);
    write_modulus(MOD_W'(2));
    send_operand(32'd7, '1);
    send_operand(32'd6, 63'd1);
    write_modulus(MOD_MAX);
    send_operand('1, '1);
    send_operand(32'(MOD_MAX), 63'd1);
    send_operand(32'(MOD_MAX) - 32'd1, 63'd2);
    send_operand(32'h8000_0000, 63'h5555_5555_5555_5555);
    drain_results();
  endtask

  // The receiver holds off while the sender keeps offering short items. The block
  // fills its output register, finishes one more result and then stalls its input.
  // Afterwards the sender waits until every result is back.
  task automatic test_backpressure();
    write_modulus(MOD_W'($urandom_range(1000, 100000)));
    send_idle_pct = 0;
    -> hold_go;
    repeat (8) begin
      send_operand($urandom, EXP_W'($urandom_range(1, 15)));
    end
    send_idle_pct = IDLE_PCT;
    drain_results();
  endtask

  // A stretch in which neither side idles.
  task automatic test_no_idle();
    send_idle_pct  = 0;
    ready_idle_pct = 0;
    repeat (15) begin
      send_operand(random_base(), random_exponent());
    end
    send_idle_pct  = IDLE_PCT;
    ready_idle_pct = IDLE_PCT;
    drain_results();
  endtask

  // Random items under several moduli: the largest, full-range random values, small
  // values, the reset value and random values with the top bit set.
  task automatic test_random_moduli();
    logic [MOD_W-1:0] next_mod;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          next_mod = MOD_MAX;
        end
        1: begin
          next_mod = MOD_W'($urandom);
        end
        2: begin
          next_mod = MOD_W'($urandom_range(2, 64));
        end
        3: begin
          next_mod = me_pkg::MODULUS_RESET[MOD_W-1:0];
        end
        default: begin
          next_mod = {1'b1, (MOD_W-1)'($urandom)};
        end
      endcase
      write_modulus(next_mod);
      repeat (22) begin
        send_operand(random_base(), random_exponent());
      end
    end
    drain_results();
  endtask

  // The hold-off runs in its own process and counts its own cycles, so the sender is
  // free to keep offering beats during it.
  always begin
    @(hold_go);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // The receiver idles at random, or for the whole hold-off when one is running.
  always @(posedge clk) begin
    if (rst || hold_active) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= ready_idle_pct);
    end
  end

  // Every accepted result beat is checked against the oldest owed power. Signals are
  // read at the edge itself, so they hold the values from before it.
  always @(posedge clk) begin
    power_job_t want;
    if (!rst) begin
      if (operand.valid && !operand.ready) begin
        stall_cycles++;
      end
      if (result.valid && result.ready) begin
        results_seen++;
        if (pending_powers.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no item outstanding",
                                    result.power_mod));
        end else begin
          want = pending_powers.pop_front();
          if (result.power_mod !== want.power_mod) begin
            report_mismatch($sformatf("%0d^%0d mod %0d: got %0d, want %0d",
                                      want.base_value, want.exponent, want.modulus,
                                      result.power_mod, want.power_mod));
          end
        end
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    operand.valid      <= 1'b0;
    operand.base_value <= '0;
    operand.exponent   <= '0;
    modulus_now        = me_pkg::MODULUS_RESET[MOD_W-1:0];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_modulus();
    test_modulus_extremes();
    test_backpressure();
    test_no_idle();
    test_random_moduli();

    // Nothing is owed any more. Any beat that still shows up is reported by the checker.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d operand beats and %0d result beats under %0d modulus writes.",
             items_sent, results_seen, modulus_writes);
    $display("The operand channel was stalled for %0d cycles. Mismatches: %0d.",
             stall_cycles, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("Timed out with %0d results still owed.", pending_powers.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== modular_exponentiation.f =====
hw/rtl/me_pkg.sv
hw/rtl/me_stream_if.sv
hw/rtl/me_modmul.sv
hw/rtl/modular_exponentiation.sv
verif/tb.sv
